// ----- src/least_loaded_server_wait_tracker_unit_macros.svh -----
// Assertion macros for the least-loaded server tracker.
`ifndef LEAST_LOADED_SERVER_WAIT_TRACKER_UNIT_MACROS_SVH
`define LEAST_LOADED_SERVER_WAIT_TRACKER_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define LLSWT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("llswt assertion failed");

// Next-cycle implication, disabled during reset.
`define LLSWT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("llswt assertion failed");

`endif

// ----- src/llswt_pkg.sv -----
package llswt_pkg;

  localparam int ARR_W      = 32;
  localparam int REM_W      = 32;
  localparam int SVC_W      = 16;
  localparam int CNT_W      = 16;
  localparam int SCNT_W     = 5;
  localparam int LIMIT_W    = 16;
  localparam int OUT_IDX_W  = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int CMP_W      = 7;

  localparam logic [SCNT_W-1:0]  RESET_SERVER_COUNT = 5'd16;
  localparam logic [LIMIT_W-1:0] RESET_WAIT_LIMIT   = 16'd20;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SERVER_COUNT = 2'd0,
    CFG_WAIT_LIMIT   = 2'd1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINAL
  } state_t;

  typedef struct packed {
    logic start;
    logic scan;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic rd_last;
    logic out_free;
  } status_t;

endpackage

// ----- src/least_loaded_server_wait_tracker_unit.sv -----
// Least-loaded server assignment with late-job counting.
// Input channel (in_valid/in_ready): one beat is one job, arrival_time and
// service_time. Output channel (out_valid/out_ready): one beat per job with
// chosen_server, wait_time, late and late_total.
// Config: cfg_write with cfg_index 0 (server_count) or 1 (wait_limit) and
// cfg_data; write only while no job is in flight. Other indexes are ignored.
// Each job makes one pass over the remaining-time RAM (separate read and
// write ports): a read, a decrement write-back and a compare per server, then
// one update, which registers the result; no new job is taken before it.
// The result sits in an output register, so the next job is accepted while
// it waits; a receiver stall that lasts until the next job's final step holds
// the block in that step until the output register frees.
// Reset (synchronous, rst high) clears all remaining times, the arrival
// history and the late count at once, and restores server_count = 16 and
// wait_limit = 20; the first job is taken in the cycle after reset drops.
module least_loaded_server_wait_tracker_unit #(
  parameter int MAX_SERVERS = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [llswt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [llswt_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [llswt_pkg::ARR_W-1:0]      arrival_time,
  input  logic [llswt_pkg::SVC_W-1:0]      service_time,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [llswt_pkg::OUT_IDX_W-1:0]  chosen_server,
  output logic [llswt_pkg::REM_W-1:0]      wait_time,
  output logic                             late,
  output logic [llswt_pkg::CNT_W-1:0]      late_total
);

  import llswt_pkg::*;

  `include "least_loaded_server_wait_tracker_unit_macros.svh"

  cmd_t    cmd;
  status_t status;

  llswt_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .status  (status),
    .cmd     (cmd)
  );

  llswt_dp #(
    .MAX_SERVERS(MAX_SERVERS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .arrival_time (arrival_time),
    .service_time (service_time),
    .out_ready    (out_ready),
    .out_valid    (out_valid),
    .chosen_server(chosen_server),
    .wait_time    (wait_time),
    .late         (late),
    .late_total   (late_total)
  );

  `LLSWT_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
  `LLSWT_ASSERT_IMP(a_finish_needs_slot, cmd.finish, status.out_free)
  `LLSWT_ASSERT_IMP(a_late_counted, out_valid && late, late_total != '0)

endmodule

// ----- src/llswt_ram.sv -----
module llswt_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/llswt_ctrl.sv -----
module llswt_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  llswt_pkg::status_t status,
  output llswt_pkg::cmd_t    cmd
);

  import llswt_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = !rst;
        if (in_valid && !rst) begin
          cmd.start  = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (status.rd_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_FINAL;
      end
      ST_FINAL: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- src/llswt_dp.sv -----
module llswt_dp #(
  parameter int MAX_SERVERS = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  llswt_pkg::cmd_t                  cmd,
  output llswt_pkg::status_t               status,
  input  logic                             cfg_write,
  input  logic [llswt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [llswt_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic [llswt_pkg::ARR_W-1:0]      arrival_time,
  input  logic [llswt_pkg::SVC_W-1:0]      service_time,
  input  logic                             out_ready,
  output logic                             out_valid,
  output logic [llswt_pkg::OUT_IDX_W-1:0]  chosen_server,
  output logic [llswt_pkg::REM_W-1:0]      wait_time,
  output logic                             late,
  output logic [llswt_pkg::CNT_W-1:0]      late_total
);

  import llswt_pkg::*;

  localparam int IDX_W = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;

  logic [IDX_W-1:0]       rd_idx, proc_idx, best_idx;
  logic                   proc_valid, rd_vld;
  logic [MAX_SERVERS-1:0] ent_valid;
  logic [REM_W-1:0]       rdata, cur, dec, best_orig, best_dec, elapsed;
  logic [ARR_W-1:0]       last_arrival;
  logic                   seen_first;
  logic [SVC_W-1:0]       service;
  logic [SCNT_W-1:0]      server_count;
  logic [LIMIT_W-1:0]     wait_limit;
  logic [CNT_W-1:0]       late_counter, late_counter_next;
  logic                   active, take_best, is_late;
  logic [REM_W:0]         grown;
  logic [REM_W-1:0]       final_rem;
  logic                   ram_we;
  logic [IDX_W-1:0]       ram_waddr;
  logic [REM_W-1:0]       ram_wdata;

  llswt_ram #(
    .WIDTH (REM_W),
    .DEPTH (MAX_SERVERS),
    .ADDR_W(IDX_W)
  ) u_rem_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(rd_idx),
    .rdata(rdata)
  );

  // never-written entries read as zero
  assign cur = rd_vld ? rdata : '0;
  assign dec = (cur > elapsed) ? cur - elapsed : '0;

  assign active    = (proc_idx == '0) || (CMP_W'(proc_idx) < CMP_W'(server_count));
  assign take_best = proc_valid && active && ((proc_idx == '0) || (cur < best_orig));

  assign grown     = {1'b0, best_dec} + (REM_W + 1)'(service);
  assign final_rem = grown[REM_W] ? '1 : grown[REM_W-1:0];

  assign ram_we    = proc_valid || cmd.finish;
  assign ram_waddr = cmd.finish ? best_idx : proc_idx;
  assign ram_wdata = cmd.finish ? final_rem : dec;

  assign is_late           = best_dec > REM_W'(wait_limit);
  assign late_counter_next = (is_late && late_counter != '1) ? late_counter + CNT_W'(1)
                                                              : late_counter;

  assign status.rd_last  = (rd_idx == IDX_W'(MAX_SERVERS - 1));
  assign status.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      proc_valid   <= 1'b0;
      ent_valid    <= '0;
      seen_first   <= 1'b0;
      last_arrival <= '0;
      late_counter <= '0;
      server_count <= RESET_SERVER_COUNT;
      wait_limit   <= RESET_WAIT_LIMIT;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_SERVER_COUNT: server_count <= cfg_data[SCNT_W-1:0];
          CFG_WAIT_LIMIT:   wait_limit   <= cfg_data[LIMIT_W-1:0];
          default: ;
        endcase
      end
      if (cmd.start) begin
        elapsed      <= (seen_first && arrival_time >= last_arrival) ?
                        arrival_time - last_arrival : '0;
        last_arrival <= arrival_time;
        seen_first   <= 1'b1;
        service      <= service_time;
        rd_idx       <= '0;
      end
      if (cmd.scan) begin
        rd_idx   <= rd_idx + IDX_W'(1);
        rd_vld   <= ent_valid[rd_idx];
        proc_idx <= rd_idx;
      end
      proc_valid <= cmd.scan;
      if (take_best) begin
        best_idx  <= proc_idx;
        best_orig <= cur;
        best_dec  <= dec;
      end
      if (ram_we) begin
        ent_valid[ram_waddr] <= 1'b1;
      end
      if (cmd.finish) begin
        chosen_server <= OUT_IDX_W'(best_idx);
        wait_time     <= best_dec;
        late          <= is_late;
        late_total    <= late_counter_next;
        late_counter  <= late_counter_next;
        out_valid     <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
